@@ design/shsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sensor health score curve: shared types and widths
// Field widths, datapath widths, register and curve codes, and the
// per-request side-band flags.
// ----------------------------------------------------------------------------
package shsc_pkg;

   localparam int VALUE_W    = 16;
   localparam int SCORE_W    = 15;
   localparam int STRENGTH_W = 15;
   localparam int SHAPE_W    = 2;

   // divider: numerator, denominator and quotient widths
   localparam int NUM_W = 40;
   localparam int DEN_W = 17;
   localparam int QUO_W = 20;

   // Q30 value that can hold 1.0
   localparam int G_W = 31;

   localparam logic [SCORE_W-1:0] SCORE_FULL = 15'd25600;

   // register index, byte address 4*index
   typedef enum logic [2:0] {
      REG_RANGE_LOW  = 3'd0,
      REG_RANGE_HIGH = 3'd1,
      REG_IDEAL      = 3'd2,
      REG_EDGE       = 3'd3,
      REG_STRENGTH   = 3'd4,
      REG_SHAPE      = 3'd5
   } reg_index_type;

   typedef enum logic [SHAPE_W-1:0] {
      SHAPE_LINEAR   = 2'd0,
      SHAPE_BELL     = 2'd1,
      SHAPE_PLATEAU  = 2'd2,
      SHAPE_BELL_ALT = 2'd3
   } shape_type;

   typedef struct packed {
      logic outside;   // sample outside the window
      logic full;      // score is 100 regardless of the curve
      logic bell;      // bell curve, else ramp quotient is the score add-on
      logic g_one;     // gaussian forced to 1
      logic g_zero;    // gaussian forced to 0
   } side_type;

endpackage

@@ design/shsc_div.sv @@
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, MSB first; numerator must be below den << QUO_W.
// ----------------------------------------------------------------------------
module shsc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_vld,
   input  logic [shsc_pkg::NUM_W-1:0]    in_num,
   input  logic [shsc_pkg::DEN_W-1:0]    in_den,
   input  shsc_pkg::side_type            in_side,
   output logic                          out_vld,
   output logic [shsc_pkg::QUO_W-1:0]    out_quo,
   output shsc_pkg::side_type            out_side
);

   localparam int STAGES = shsc_pkg::QUO_W;

   logic                         vld_ff  [STAGES];
   logic [shsc_pkg::NUM_W-1:0]   rem_ff  [STAGES];
   logic [shsc_pkg::NUM_W-1:0]   rem_in  [STAGES];
   logic [shsc_pkg::DEN_W-1:0]   den_ff  [STAGES];
   logic [shsc_pkg::QUO_W-1:0]   quo_ff  [STAGES];
   logic [shsc_pkg::QUO_W-1:0]   quo_in  [STAGES];
   shsc_pkg::side_type           side_ff [STAGES];

   always_comb begin
      logic [shsc_pkg::NUM_W-1:0] src;
      logic [shsc_pkg::NUM_W-1:0] sub;
      logic [shsc_pkg::QUO_W-1:0] qsrc;
      logic [shsc_pkg::DEN_W-1:0] dsrc;
      for (int k = 0; k < STAGES; k++) begin
         src  = (k == 0) ? in_num : rem_ff[(k == 0) ? 0 : k-1];
         qsrc = (k == 0) ? '0 : quo_ff[(k == 0) ? 0 : k-1];
         dsrc = (k == 0) ? in_den : den_ff[(k == 0) ? 0 : k-1];
         sub  = shsc_pkg::NUM_W'(dsrc) << (STAGES-1-k);
         if (src >= sub) begin
            rem_in[k] = src - sub;
            quo_in[k] = qsrc | (shsc_pkg::QUO_W'(1) << (STAGES-1-k));
         end else begin
            rem_in[k] = src;
            quo_in[k] = qsrc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) vld_ff[k] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 1; k < STAGES; k++) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = quo_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];

endmodule

@@ design/shsc_exp.sv @@
// ----------------------------------------------------------------------------
// Gaussian evaluation pipeline
// From r = |d|/sigma (Q16): x = r^2/2, 5th order series of exp(-x/256) in
// Q30, then eight rounded squarings. The ramp quotient rides along unchanged.
// ----------------------------------------------------------------------------
module shsc_exp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          enable,
   input  logic                          in_vld,
   input  logic [shsc_pkg::QUO_W-1:0]    in_quo,
   input  shsc_pkg::side_type            in_side,
   output logic                          out_vld,
   output logic [shsc_pkg::SCORE_W-1:0]  out_quo,
   output logic [shsc_pkg::G_W-1:0]      out_g,
   output shsc_pkg::side_type            out_side
);

   localparam int SQUARES = 8;
   localparam int STAGES  = 7 + SQUARES;

   // floor(n/d) = (n * ceil(2^32/d)) >> 32, exact for the ranges here
   localparam logic [29:0] RECIP_6   = 30'd715827883;
   localparam logic [27:0] RECIP_24  = 28'd178956971;
   localparam logic [25:0] RECIP_120 = 26'd35791395;

   localparam logic [31:0] ONE_Q30  = 32'h4000_0000;
   localparam logic [61:0] HALF_Q30 = 62'h2000_0000;

   logic                          vld_ff  [STAGES];
   logic [shsc_pkg::SCORE_W-1:0]  quo_ff  [STAGES];
   shsc_pkg::side_type            side_ff [STAGES];

   logic [27:0] e1_y_ff, e1_y_in;
   logic [27:0] e2_y_ff;
   logic [25:0] e2_t2_ff, e2_t2_in;
   logic [27:0] e3_y_ff;
   logic [23:0] e3_t3_ff, e3_t3_in;
   logic [24:0] e3_h2_ff;
   logic [27:0] e4_y_ff;
   logic [21:0] e4_t4_ff, e4_t4_in;
   logic [24:0] e4_h2_ff;
   logic [21:0] e4_c3_ff, e4_c3_in;
   logic [27:0] e5_y_ff;
   logic [19:0] e5_t5_ff, e5_t5_in;
   logic [24:0] e5_h2_ff;
   logic [21:0] e5_c3_ff;
   logic [17:0] e5_c4_ff, e5_c4_in;
   logic [27:0] e6_y_ff;
   logic [24:0] e6_h2_ff;
   logic [21:0] e6_c3_ff;
   logic [17:0] e6_c4_ff;
   logic [13:0] e6_c5_ff, e6_c5_in;
   logic [shsc_pkg::G_W-1:0] e7_e_ff, e7_e_in;
   logic [shsc_pkg::G_W-1:0] sq_ff [SQUARES];
   logic [shsc_pkg::G_W-1:0] sq_in [SQUARES];

   always_comb begin
      logic [39:0] r_sq;
      logic [55:0] p2;
      logic [53:0] p3, d3;
      logic [51:0] p4;
      logic [49:0] p5, d4;
      logic [45:0] d5;
      logic [31:0] sum;
      logic [61:0] s;
      logic [shsc_pkg::G_W-1:0] src;

      // x = r^2 >> 17 in Q16, y = x << 6 is x/256 in Q30
      r_sq    = 40'(in_quo) * 40'(in_quo);
      e1_y_in = {r_sq[38:17], 6'b0};

      p2       = 56'(e1_y_ff) * 56'(e1_y_ff);
      e2_t2_in = p2[55:30];

      p3       = 54'(e2_t2_ff) * 54'(e2_y_ff);
      e3_t3_in = p3[53:30];

      p4       = 52'(e3_t3_ff) * 52'(e3_y_ff);
      e4_t4_in = p4[51:30];
      d3       = 54'(e3_t3_ff) * 54'(RECIP_6);
      e4_c3_in = d3[53:32];

      p5       = 50'(e4_t4_ff) * 50'(e4_y_ff);
      e5_t5_in = p5[49:30];
      d4       = 50'(e4_t4_ff) * 50'(RECIP_24);
      e5_c4_in = d4[49:32];

      d5       = 46'(e5_t5_ff) * 46'(RECIP_120);
      e6_c5_in = d5[45:32];

      sum = ONE_Q30 + 32'(e6_h2_ff) + 32'(e6_c4_ff)
            - 32'(e6_y_ff) - 32'(e6_c3_ff) - 32'(e6_c5_ff);
      e7_e_in = sum[shsc_pkg::G_W-1:0];

      for (int k = 0; k < SQUARES; k++) begin
         src      = (k == 0) ? e7_e_ff : sq_ff[(k == 0) ? 0 : k-1];
         s        = 62'(src) * 62'(src) + HALF_Q30;
         sq_in[k] = s[60:30];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < STAGES; k++) vld_ff[k] <= 1'b0;
      end else if (enable) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < STAGES; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quo_ff[0]  <= in_quo[shsc_pkg::SCORE_W-1:0];
         side_ff[0] <= in_side;
         for (int k = 1; k < STAGES; k++) begin
            quo_ff[k]  <= quo_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
         e1_y_ff  <= e1_y_in;
         e2_y_ff  <= e1_y_ff;
         e2_t2_ff <= e2_t2_in;
         e3_y_ff  <= e2_y_ff;
         e3_t3_ff <= e3_t3_in;
         e3_h2_ff <= e2_t2_ff[25:1];
         e4_y_ff  <= e3_y_ff;
         e4_t4_ff <= e4_t4_in;
         e4_h2_ff <= e3_h2_ff;
         e4_c3_ff <= e4_c3_in;
         e5_y_ff  <= e4_y_ff;
         e5_t5_ff <= e5_t5_in;
         e5_h2_ff <= e4_h2_ff;
         e5_c3_ff <= e4_c3_ff;
         e5_c4_ff <= e5_c4_in;
         e6_y_ff  <= e5_y_ff;
         e6_h2_ff <= e5_h2_ff;
         e6_c3_ff <= e5_c3_ff;
         e6_c4_ff <= e5_c4_ff;
         e6_c5_ff <= e6_c5_in;
         e7_e_ff  <= e7_e_in;
         for (int k = 0; k < SQUARES; k++) sq_ff[k] <= sq_in[k];
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_quo  = quo_ff[STAGES-1];
   assign out_side = side_ff[STAGES-1];
   assign out_g    = sq_ff[SQUARES-1];

endmodule

@@ design/sensor_health_score_curve_unit.sv @@
// ----------------------------------------------------------------------------
// Sensor health score curve unit
// Maps a signed Q8.8 sample to a Q7.8 health score with linear, bell or
// plateau curve shapes set through an APB register port.
// ----------------------------------------------------------------------------
// A fully pipelined unit: one request is accepted every clock cycle unless
// the pipeline holds, and results leave in request order. Requests pass the
// 20-stage bit-per-stage divider followed by the 15-stage exp/squaring chain;
// every request runs through the same stages whatever the curve shape. When
// rsp_ready is low with a result waiting, the whole pipeline holds. Registers
// (byte address 4*i): range_low, range_high, ideal_point, edge_score,
// curve_strength, curve_shape; write them only while no request is in flight.
module sensor_health_score_curve_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [15:0]             req_sample_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [14:0]                    rsp_health_score,
   output logic                           rsp_outside_window,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [4:0]                     paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // floor(span/5) as (span * ceil(2^19/5)) >> 19
   localparam logic [16:0] RECIP_5 = 17'd104858;
   localparam logic [45:0] HALF_Q30 = 46'h2000_0000;
   localparam logic [shsc_pkg::G_W-1:0] ONE_Q30 = 31'h4000_0000;

   // ---------------- registers ----------------
   logic signed [15:0]               low_ff, high_ff, ideal_ff;
   logic [shsc_pkg::SCORE_W-1:0]     edge_ff;
   logic [shsc_pkg::STRENGTH_W-1:0]  strength_ff;
   logic [shsc_pkg::SHAPE_W-1:0]     shape_ff;
   logic                             wr_en;
   logic [2:0]                       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= 16'sd0;
         high_ff     <= 16'sd25600;
         ideal_ff    <= 16'sd12800;
         edge_ff     <= 15'd5120;
         strength_ff <= 15'd1536;
         shape_ff    <= shsc_pkg::SHAPE_BELL;
      end else if (wr_en) begin
         case (reg_idx)
            shsc_pkg::REG_RANGE_LOW:  low_ff      <= pwdata[15:0];
            shsc_pkg::REG_RANGE_HIGH: high_ff     <= pwdata[15:0];
            shsc_pkg::REG_IDEAL:      ideal_ff    <= pwdata[15:0];
            shsc_pkg::REG_EDGE:       edge_ff     <= pwdata[14:0];
            shsc_pkg::REG_STRENGTH:   strength_ff <= pwdata[14:0];
            shsc_pkg::REG_SHAPE:      shape_ff    <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         shsc_pkg::REG_RANGE_LOW:  prdata = {16'b0, low_ff};
         shsc_pkg::REG_RANGE_HIGH: prdata = {16'b0, high_ff};
         shsc_pkg::REG_IDEAL:      prdata = {16'b0, ideal_ff};
         shsc_pkg::REG_EDGE:       prdata = {17'b0, edge_ff};
         shsc_pkg::REG_STRENGTH:   prdata = {17'b0, strength_ff};
         shsc_pkg::REG_SHAPE:      prdata = {30'b0, shape_ff};
         default:                  prdata = '0;
      endcase
   end

   // ---------------- register-derived values ----------------
   logic signed [17:0]            lo18, hi18, id18, span18;
   logic [15:0]                   span16;
   logic [13:0]                   w_ff, w_in;
   logic [shsc_pkg::SCORE_W-1:0]  edge_c, diff;
   logic                          shape_bell;

   always_comb begin
      logic [32:0] wp;
      lo18   = {{2{low_ff[15]}}, low_ff};
      hi18   = {{2{high_ff[15]}}, high_ff};
      id18   = {{2{ideal_ff[15]}}, ideal_ff};
      span18 = hi18 - lo18;
      span16 = span18[15:0];
      wp     = 33'(span16) * 33'(RECIP_5);
      w_in   = wp[32:19];
      edge_c = (edge_ff > shsc_pkg::SCORE_FULL) ? shsc_pkg::SCORE_FULL : edge_ff;
      diff   = shsc_pkg::SCORE_FULL - edge_c;
      shape_bell = (shape_ff == shsc_pkg::SHAPE_BELL)
                   || (shape_ff == shsc_pkg::SHAPE_BELL_ALT);
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic rsp_valid_ff;

   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;
   assign rsp_valid = rsp_valid_ff;

   // ---------------- P1: capture sample ----------------
   logic               p1_vld_ff;
   logic signed [15:0] p1_v_ff;

   // ---------------- P2: window, ramp operands, distance ----------------
   logic               p2_vld_ff;
   shsc_pkg::side_type p2_side_ff, p2_side_in;
   logic signed [17:0] p2_num_ff, p2_num_in, p2_den_ff, p2_den_in;
   logic [15:0]        p2_ad_ff, p2_ad_in;

   always_comb begin
      logic signed [17:0] v18, d18, pl_start, pl_stop, w18;
      logic               below_ideal, in_plateau, below_start;
      v18      = {{2{p1_v_ff[15]}}, p1_v_ff};
      w18      = {4'b0, w_ff};
      pl_start = id18 - w18;
      pl_stop  = id18 + w18;
      d18      = v18 - id18;
      p2_ad_in = d18[17] ? 16'(-d18) : d18[15:0];

      below_ideal = v18 <= id18;
      in_plateau  = (v18 >= pl_start) && (v18 <= pl_stop);
      below_start = v18 < pl_start;

      if (shape_ff == shsc_pkg::SHAPE_PLATEAU) begin
         p2_num_in = below_start ? (v18 - lo18) : (hi18 - v18);
         p2_den_in = below_start ? (pl_start - lo18) : (hi18 - pl_stop);
      end else begin
         p2_num_in = below_ideal ? (v18 - lo18) : (hi18 - v18);
         p2_den_in = below_ideal ? (id18 - lo18) : (hi18 - id18);
      end

      p2_side_in.outside = (v18 < lo18) || (v18 > hi18);
      p2_side_in.bell    = shape_bell;
      p2_side_in.full    = ((shape_ff == shsc_pkg::SHAPE_PLATEAU) && in_plateau)
                           || (!shape_bell && (p2_den_in <= 18'sd0));
      p2_side_in.g_one   = (span18 == 18'sd0) && (d18 == 18'sd0);
      p2_side_in.g_zero  = (span18 == 18'sd0) && (d18 != 18'sd0);
   end

   // ---------------- P3: clamp ramp numerator, |d| * strength ----------------
   logic               p3_vld_ff;
   shsc_pkg::side_type p3_side_ff;
   logic [16:0]        p3_num_ff, p3_num_in, p3_den_ff;
   logic [30:0]        p3_prod_ff, p3_prod_in;

   always_comb begin
      logic signed [17:0] n;
      if (p2_num_ff < 18'sd0)
         n = 18'sd0;
      else if (p2_num_ff > p2_den_ff)
         n = p2_den_ff;
      else
         n = p2_num_ff;
      p3_num_in  = n[16:0];
      p3_prod_in = 31'(p2_ad_ff) * 31'(strength_ff);
   end

   // ---------------- P4: divider operands ----------------
   logic                           p4_vld_ff;
   shsc_pkg::side_type             p4_side_ff, p4_side_in;
   logic [shsc_pkg::NUM_W-1:0]     p4_num_ff, p4_num_in;
   logic [shsc_pkg::DEN_W-1:0]     p4_den_ff, p4_den_in;

   always_comb begin
      logic [shsc_pkg::NUM_W-1:0] bell_num, ramp_num, limit;
      bell_num = {1'b0, p3_prod_ff, 8'b0};
      ramp_num = shsc_pkg::NUM_W'(32'(diff) * 32'(p3_num_ff))
                 + shsc_pkg::NUM_W'(p3_den_ff[16:1]);
      // r above 2^19 when num >= span * (2^19 + 1)
      limit    = (shsc_pkg::NUM_W'(span16) << 19) + shsc_pkg::NUM_W'(span16);
      p4_side_in = p3_side_ff;
      if (p3_side_ff.bell) begin
         p4_num_in = bell_num;
         p4_den_in = {1'b0, span16};
         p4_side_in.g_zero = p3_side_ff.g_zero || (bell_num >= limit);
      end else begin
         p4_num_in = ramp_num;
         p4_den_in = p3_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_v_ff    <= req_sample_value;
         p2_side_ff <= p2_side_in;
         p2_num_ff  <= p2_num_in;
         p2_den_ff  <= p2_den_in;
         p2_ad_ff   <= p2_ad_in;
         p3_side_ff <= p2_side_ff;
         p3_num_ff  <= p3_num_in;
         p3_den_ff  <= p2_den_ff[16:0];
         p3_prod_ff <= p3_prod_in;
         p4_side_ff <= p4_side_in;
         p4_num_ff  <= p4_num_in;
         p4_den_ff  <= p4_den_in;
      end
   end

   // ---------------- divider and gaussian ----------------
   logic                           dv_vld;
   logic [shsc_pkg::QUO_W-1:0]     dv_quo;
   shsc_pkg::side_type             dv_side;
   logic                           ex_vld;
   logic [shsc_pkg::SCORE_W-1:0]   ex_quo;
   logic [shsc_pkg::G_W-1:0]       ex_g;
   shsc_pkg::side_type             ex_side;

   shsc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_vld   (p4_vld_ff),
      .in_num   (p4_num_ff),
      .in_den   (p4_den_ff),
      .in_side  (p4_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   shsc_exp u_exp (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_vld   (dv_vld),
      .in_quo   (dv_quo),
      .in_side  (dv_side),
      .out_vld  (ex_vld),
      .out_quo  (ex_quo),
      .out_g    (ex_g),
      .out_side (ex_side)
   );

   // ---------------- F1: scale gaussian ----------------
   logic                          f1_vld_ff;
   shsc_pkg::side_type            f1_side_ff;
   logic [shsc_pkg::SCORE_W-1:0]  f1_quo_ff;
   logic [shsc_pkg::SCORE_W-1:0]  f1_bell_ff, f1_bell_in;

   always_comb begin
      logic [shsc_pkg::G_W-1:0] g;
      logic [45:0]              p;
      priority if (ex_side.g_one)  g = ONE_Q30;
      else if (ex_side.g_zero)     g = '0;
      else                         g = ex_g;
      p          = 46'(diff) * 46'(g) + HALF_Q30;
      f1_bell_in = p[44:30];
   end

   // ---------------- output register ----------------
   logic [shsc_pkg::SCORE_W-1:0] score_ff, score_in;
   logic                         outside_ff;

   always_comb begin
      priority if (f1_side_ff.outside) score_in = '0;
      else if (f1_side_ff.full)        score_in = shsc_pkg::SCORE_FULL;
      else if (f1_side_ff.bell)        score_in = edge_c + f1_bell_ff;
      else                             score_in = edge_c + f1_quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         f1_vld_ff    <= ex_vld;
         rsp_valid_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_side_ff <= ex_side;
         f1_quo_ff  <= ex_quo;
         f1_bell_ff <= f1_bell_in;
         score_ff   <= score_in;
         outside_ff <= f1_side_ff.outside;
      end
   end

   assign rsp_health_score   = score_ff;
   assign rsp_outside_window = outside_ff;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor health score curve unit testbench
// Drives samples through the valid/ready request channel under several window
// and curve settings. A scoreboard computes the expected score and window flag
// for each accepted request and compares them in order with the results.
// ----------------------------------------------------------------------------

class score_board;
   longint lo, hi, ideal, edge_q, strength;
   logic [1:0] shape;
   logic [15:0] exp_score[$];
   bit exp_flag[$];
   int errors;

   function void reset_regs();
      lo = 0; hi = 25600; ideal = 12800; edge_q = 5120; strength = 1536;
      shape = shsc_pkg::SHAPE_BELL;
      errors = 0;
   endfunction

   function void write_reg(int idx, logic [31:0] v);
      case (idx)
         shsc_pkg::REG_RANGE_LOW:  lo = longint'($signed(v[15:0]));
         shsc_pkg::REG_RANGE_HIGH: hi = longint'($signed(v[15:0]));
         shsc_pkg::REG_IDEAL:      ideal = longint'($signed(v[15:0]));
         shsc_pkg::REG_EDGE:       edge_q = longint'(v[14:0]);
         shsc_pkg::REG_STRENGTH:   strength = longint'(v[14:0]);
         shsc_pkg::REG_SHAPE:      shape = v[1:0];
         default: ;
      endcase
   endfunction

   function longint edge_sat();
      return (edge_q > 25600) ? 25600 : edge_q;
   endfunction

   function longint ramp(longint num, longint den);
      longint e;
      e = edge_sat();
      if (den <= 0) return 25600;
      if (num < 0) num = 0;
      if (num > den) num = den;
      return e + ((25600 - e) * num + den / 2) / den;
   endfunction

   function longint unsigned exp_neg(longint unsigned xq16);
      longint unsigned y, t2, t3, t4, t5, e;
      y = xq16 << 6;
      t2 = (y * y) >> 30;
      t3 = (t2 * y) >> 30;
      t4 = (t3 * y) >> 30;
      t5 = (t4 * y) >> 30;
      e = (64'd1 << 30) + t2 / 2 + t4 / 24 - y - t3 / 6 - t5 / 120;
      for (int i = 0; i < 8; i++) e = (e * e + (64'd1 << 29)) >> 30;
      return e;
   endfunction

   function longint bell(longint v);
      longint e, span, d;
      longint unsigned ad, r, g;
      e = edge_sat();
      span = hi - lo;
      d = v - ideal;
      ad = (d < 0) ? -d : d;
      if (span <= 0) g = (ad == 0) ? (64'd1 << 30) : 0;
      else begin
         r = (ad * strength * 256) / span;
         g = (r > (64'd1 << 19)) ? 0 : exp_neg((r * r) >> 17);
      end
      return e + longint'(((25600 - e) * g + (64'd1 << 29)) >> 30);
   endfunction

   function void note_sample(logic [15:0] s);
      longint v, sc, w;
      v = longint'($signed(s));
      if (v < lo || v > hi) begin
         exp_score.push_back(0); exp_flag.push_back(1);
         return;
      end
      if (shape == shsc_pkg::SHAPE_LINEAR)
         sc = (v <= ideal) ? ramp(v - lo, ideal - lo) : ramp(hi - v, hi - ideal);
      else if (shape == shsc_pkg::SHAPE_PLATEAU) begin
         w = (hi - lo) / 5;
         if (v >= ideal - w && v <= ideal + w) sc = 25600;
         else if (v < ideal - w) sc = ramp(v - lo, ideal - w - lo);
         else sc = ramp(hi - v, hi - ideal - w);
      end else sc = bell(v);
      exp_score.push_back(sc[14:0]); exp_flag.push_back(0);
   endfunction

   function void check_result(logic [14:0] sc, logic fl);
      if (exp_score.size() == 0) begin
         $error("unexpected result score=%0d flag=%0d", sc, fl);
         errors++;
         return;
      end
      if (exp_score[0][14:0] !== sc) begin
         $error("health_score expected %0d actual %0d", exp_score[0], sc);
         errors++;
      end
      if (exp_flag[0] !== fl) begin
         $error("outside_window expected %0d actual %0d", exp_flag[0], fl);
         errors++;
      end
      void'(exp_score.pop_front()); void'(exp_flag.pop_front());
   endfunction
endclass

module tb;
   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0;
   logic [15:0] req_sample_value = 0;
   logic req_ready, rsp_valid, rsp_outside_window;
   logic [14:0] rsp_health_score;
   logic psel = 0, penable = 0, pwrite = 0, pready;
   logic [4:0] paddr = 0;
   logic [31:0] pwdata = 0, prdata;

   score_board sb;
   bit rx_idle_on = 1, tx_idle_on = 1, hold_off = 0;
   longint cycles = 0;

   sensor_health_score_curve_unit DUT (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 2000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // receiver with random stalls; long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            hold_off = 0;
            continue;
         end
         if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 9);
            rsp_ready <= 0;
            repeat (n - 1) @(posedge clock);
         end else rsp_ready <= 1;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_health_score, rsp_outside_window);

   task automatic csr_write(int idx, logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= v;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      sb.write_reg(idx, v);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_sample(logic [15:0] s);
      if (tx_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid <= 1; req_sample_value <= s;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(s);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.exp_score.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_all(logic [15:0] l, logic [15:0] h, logic [15:0] i,
                          logic [14:0] e, logic [14:0] st, logic [1:0] sh);
      csr_write(shsc_pkg::REG_RANGE_LOW, {16'h0, l});
      csr_write(shsc_pkg::REG_RANGE_HIGH, {16'h0, h});
      csr_write(shsc_pkg::REG_IDEAL, {16'h0, i});
      csr_write(shsc_pkg::REG_EDGE, {17'h0, e});
      csr_write(shsc_pkg::REG_STRENGTH, {17'h0, st});
      csr_write(shsc_pkg::REG_SHAPE, {30'h0, sh});
   endtask

   // mostly samples near the window, some anywhere
   function automatic logic [15:0] pick_sample();
      longint l, h;
      l = sb.lo; h = sb.hi;
      if ($urandom_range(0, 4) == 0 || l > h) return 16'($urandom);
      return 16'(l + longint'($urandom_range(0, 32'(h - l))));
   endfunction

   initial begin
      logic [15:0] lo_v, hi_v, t;
      sb = new();
      sb.reset_regs();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults, field extremes, special cases
      send_sample(16'h8000); send_sample(16'h7fff); send_sample(16'h0000);
      send_sample(16'hffff); send_sample(16'd25600); send_sample(16'd25601);
      send_sample(16'd12800); send_sample(16'd100);
      drain();
      set_all(16'd0, 16'd25600, 16'd12800, 15'd30000, 15'd1536,
              shsc_pkg::SHAPE_LINEAR);
      send_sample(16'd0); send_sample(16'd6400); send_sample(16'd12800);
      send_sample(16'd20000);
      drain();
      set_all(16'd0, 16'd25600, 16'd0, 15'd0, 15'd0, shsc_pkg::SHAPE_BELL_ALT);
      send_sample(16'd0); send_sample(16'd25600); send_sample(16'd3);
      drain();
      set_all(16'd100, 16'd100, 16'd100, 15'd5120, 15'h7fff, shsc_pkg::SHAPE_BELL);
      send_sample(16'd100); send_sample(16'd99);
      drain();
      set_all(16'd500, 16'd100, 16'd300, 15'd5120, 15'd1, shsc_pkg::SHAPE_PLATEAU);
      send_sample(16'd300); send_sample(16'd100);
      drain();
      set_all(16'h8000, 16'h7fff, 16'h8000, 15'd0, 15'h7fff, shsc_pkg::SHAPE_PLATEAU);
      send_sample(16'h8000); send_sample(16'h7fff); send_sample(16'h0000);
      drain();

      // random phases
      for (int ph = 0; ph < 15; ph++) begin
         lo_v = 16'($urandom); hi_v = 16'($urandom);
         if ($urandom_range(0, 7) != 0 && $signed(lo_v) > $signed(hi_v)) begin
            t = lo_v; lo_v = hi_v; hi_v = t;
         end
         t = 16'($signed(lo_v) + ($signed(hi_v) - $signed(lo_v)) / 2);
         set_all(lo_v, hi_v, ($urandom_range(0, 3) == 0) ? 16'($urandom) : t,
                 15'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 25600)),
                 15'($urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 4000)),
                 2'(ph));
         if (ph == 3) hold_off = 1;
         if (ph == 13) begin tx_idle_on = 0; rx_idle_on = 0; end
         repeat (100) send_sample(pick_sample());
         drain();
      end

      if (sb.errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
